[sv/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the greedy box suppression unit.
// ----------------------------------------------------------------------------
package gbn_pkg;
  localparam int MaxBoxes  = 64;
  localparam int CoordBits = 13;
  localparam int IdxBits   = $clog2(MaxBoxes);
  localparam int CntBits   = $clog2(MaxBoxes + 1);
  localparam int SizeBits  = 12;
  localparam int ScoreBits = 16;
  localparam int CfgBits   = 16;
  localparam int SpanBits  = CoordBits + 2;
  localparam int AreaBits  = 2 * SizeBits;
  localparam int UniBits   = AreaBits + 2;
  localparam int ProdBits  = UniBits + CfgBits;

  localparam logic [CfgBits-1:0] ScoreThrRst = 16'd16384;
  localparam logic [CfgBits-1:0] IouThrRst   = 16'd29491;

  localparam logic CfgScoreThr = 1'b0;
  localparam logic CfgIouThr   = 1'b1;

  typedef struct packed {
    logic signed [CoordBits-1:0] left;
    logic signed [CoordBits-1:0] top;
    logic [SizeBits-1:0]         wid;
    logic [SizeBits-1:0]         hgt;
  } geom_t;

  typedef enum logic [4:0] {
    StLoad, StSortRd, StSortKey, StSortIss, StSortOrd, StSortCmp, StSortPut,
    StPassRd, StPassSc, StPassChk, StEmit, StPairRd, StPairGeo, StPairA,
    StPairB, StPairC, StPairD, StDone
  } state_e;
endpackage

[sv/greedy_box_nms_unit.sv]
// ----------------------------------------------------------------------------
// greedy_box_nms_unit
// Loads boxes, sorts by score, runs greedy IoU suppression, emits kept indices.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// box     | in  | box_valid/box_stall | box_left..final_box
// kept    | out | kept_vld/kept_stall | kept_index, kept_valid, run_end
// cfg     | in  | cfg_we_i            | cfg_idx_i, cfg_data_i
// The input stalls from the final box until the last result is taken.
// Sort: an insertion sort of the box order by descending score.
// Suppression: each kept box is checked against every later box in score
// order. A result is held one deep so the last one carries run_end; kept
// stall extends the emit and done cycles.
// Reset clears the count and the FSM and loads the default thresholds; marks clear as boxes load.
// ----------------------------------------------------------------------------
module greedy_box_nms_unit import gbn_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [CfgBits-1:0]          cfg_data_i,
  input  logic                        box_valid_i,
  output logic                        box_stall_o,
  input  logic signed [CoordBits-1:0] box_left_i,
  input  logic signed [CoordBits-1:0] box_top_i,
  input  logic [SizeBits-1:0]         box_width_i,
  input  logic [SizeBits-1:0]         box_height_i,
  input  logic [ScoreBits-1:0]        box_score_i,
  input  logic                        final_box_i,
  output logic                        kept_vld_o,
  input  logic                        kept_stall_i,
  output logic [IdxBits-1:0]          kept_index_o,
  output logic                        kept_valid_o,
  output logic                        run_end_o
);
  geom_t                geom_mem  [MaxBoxes];
  logic [ScoreBits-1:0] score_mem [MaxBoxes];
  logic [IdxBits-1:0]   order_mem [MaxBoxes];
  logic                 mark_mem  [MaxBoxes];

  state_e               state_q, state_d;
  logic [CntBits-1:0]   cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [CfgBits-1:0]   sthr_q, ithr_q;
  logic [ScoreBits-1:0] key_q, key_d;
  logic [IdxBits-1:0]   a_q, a_d, b_q, b_d;
  geom_t                ga_q, ga_d;
  logic                 hold_q, hold_d;
  logic [IdxBits-1:0]   hold_idx_q, hold_idx_d;

  logic                 acc, load_we;
  logic                 o_we, m_we, m_wd;
  logic [IdxBits-1:0]   g_ra, s_ra, o_ra, m_ra, o_wa, o_wd, m_wa;
  geom_t                g_rd_q;
  logic [ScoreBits-1:0] s_rd_q;
  logic [IdxBits-1:0]   o_rd_q;
  logic                 m_rd_q;

  logic [SizeBits-1:0]        iw_q, ih_q;
  logic [AreaBits-1:0]        area_a_q, area_b_q, inter_q;
  logic [UniBits-1:0]         uni_q;
  logic signed [SpanBits-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [SpanBits-1:0] lo_x, hi_x, lo_y, hi_y, nx, ny;
  logic                       exceed;

  assign acc     = box_valid_i && !box_stall_o;
  assign load_we = acc && (cnt_q < CntBits'(MaxBoxes));

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      geom_mem[cnt_q[IdxBits-1:0]]  <= '{left: box_left_i, top: box_top_i,
                                         wid: box_width_i, hgt: box_height_i};
      score_mem[cnt_q[IdxBits-1:0]] <= box_score_i;
    end
    if (o_we) order_mem[o_wa] <= o_wd;
    if (m_we) mark_mem[m_wa] <= m_wd;
    g_rd_q <= geom_mem[g_ra];
    s_rd_q <= score_mem[s_ra];
    o_rd_q <= order_mem[o_ra];
    m_rd_q <= mark_mem[m_ra];
  end

  // pair overlap, inclusive pixel spans
  always_comb begin
    ax0 = SpanBits'(ga_q.left);
    bx0 = SpanBits'(g_rd_q.left);
    ay0 = SpanBits'(ga_q.top);
    by0 = SpanBits'(g_rd_q.top);
    ax1 = ax0 + $signed(SpanBits'(ga_q.wid)) - SpanBits'(1);
    bx1 = bx0 + $signed(SpanBits'(g_rd_q.wid)) - SpanBits'(1);
    ay1 = ay0 + $signed(SpanBits'(ga_q.hgt)) - SpanBits'(1);
    by1 = by0 + $signed(SpanBits'(g_rd_q.hgt)) - SpanBits'(1);
    lo_x = (ax0 > bx0) ? ax0 : bx0;
    lo_y = (ay0 > by0) ? ay0 : by0;
    hi_x = (ax1 < bx1) ? ax1 : bx1;
    hi_y = (ay1 < by1) ? ay1 : by1;
    nx = hi_x - lo_x + SpanBits'(1);
    ny = hi_y - lo_y + SpanBits'(1);
    exceed = ProdBits'({inter_q, {CfgBits{1'b0}}}) >
             (ProdBits'(ithr_q) * ProdBits'(uni_q));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPairA) begin
      iw_q     <= (nx > SpanBits'(0)) ? nx[SizeBits-1:0] : '0;
      ih_q     <= (ny > SpanBits'(0)) ? ny[SizeBits-1:0] : '0;
      area_a_q <= AreaBits'(ga_q.wid) * AreaBits'(ga_q.hgt);
      area_b_q <= AreaBits'(g_rd_q.wid) * AreaBits'(g_rd_q.hgt);
    end
    if (state_q == StPairB) inter_q <= AreaBits'(iw_q) * AreaBits'(ih_q);
    if (state_q == StPairC) begin
      uni_q <= UniBits'(area_a_q) + UniBits'(area_b_q) - UniBits'(inter_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad:    if (acc && final_box_i) state_d = StSortRd;
      StSortRd:  state_d = (i_q == n_q) ? StPassRd : StSortKey;
      StSortKey: state_d = (j_q == '0) ? StSortPut : StSortIss;
      StSortIss: state_d = StSortOrd;
      StSortOrd: state_d = StSortCmp;
      StSortCmp: begin
        if (s_rd_q < key_q) state_d = (j_q == CntBits'(1)) ? StSortPut : StSortIss;
        else state_d = StSortPut;
      end
      StSortPut: state_d = StSortRd;
      StPassRd:  state_d = (i_q == n_q) ? StDone : StPassSc;
      StPassSc:  state_d = StPassChk;
      StPassChk: state_d = (s_rd_q < sthr_q || m_rd_q) ? StPassRd : StEmit;
      StEmit:    if (!hold_q || !kept_stall_i) state_d = StPairRd;
      StPairRd:  state_d = (j_q == n_q) ? StPassRd : StPairGeo;
      StPairGeo: state_d = StPairA;
      StPairA:   state_d = StPairB;
      StPairB:   state_d = StPairC;
      StPairC:   state_d = StPairD;
      StPairD:   state_d = StPairRd;
      StDone:    if (!kept_stall_i) state_d = StLoad;
      default:   state_d = StLoad;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    cnt_d = cnt_q; n_d = n_q; i_d = i_q; j_d = j_q; key_d = key_q;
    a_d = a_q; b_d = b_q; ga_d = ga_q; hold_d = hold_q; hold_idx_d = hold_idx_q;
    o_we = 1'b0; o_wa = '0; o_wd = '0;
    m_we = 1'b0; m_wa = '0; m_wd = 1'b0;
    g_ra = '0; s_ra = '0; o_ra = '0; m_ra = '0;
    unique case (state_q)
      StLoad: begin
        if (load_we) begin
          cnt_d = cnt_q + 1'b1;
          m_we = 1'b1; m_wa = cnt_q[IdxBits-1:0];
        end
        if (acc && final_box_i) begin
          n_d = load_we ? cnt_q + 1'b1 : cnt_q;
          i_d = '0;
        end
      end
      StSortRd: begin
        s_ra = i_q[IdxBits-1:0];
        j_d = i_q;
        if (i_q == n_q) i_d = '0;
      end
      StSortKey: key_d = s_rd_q;
      StSortIss: o_ra = IdxBits'(j_q - 1'b1);
      StSortOrd: begin
        s_ra = o_rd_q;
        b_d = o_rd_q;
      end
      StSortCmp: begin
        if (s_rd_q < key_q) begin
          o_we = 1'b1; o_wa = j_q[IdxBits-1:0]; o_wd = b_q;
          j_d = j_q - 1'b1;
        end
      end
      StSortPut: begin
        o_we = 1'b1; o_wa = j_q[IdxBits-1:0]; o_wd = i_q[IdxBits-1:0];
        i_d = i_q + 1'b1;
      end
      StPassRd: begin
        o_ra = i_q[IdxBits-1:0];
        m_ra = i_q[IdxBits-1:0];
      end
      StPassSc: begin
        s_ra = o_rd_q; g_ra = o_rd_q; a_d = o_rd_q;
        m_ra = i_q[IdxBits-1:0];
      end
      StPassChk: begin
        ga_d = g_rd_q;
        j_d = i_q + 1'b1;
        if (s_rd_q < sthr_q || m_rd_q) i_d = i_q + 1'b1;
      end
      StEmit: begin
        if (!hold_q || !kept_stall_i) begin
          hold_d = 1'b1;
          hold_idx_d = a_q;
        end
      end
      StPairRd: begin
        o_ra = j_q[IdxBits-1:0];
        if (j_q == n_q) i_d = i_q + 1'b1;
      end
      StPairGeo: g_ra = o_rd_q;
      StPairD: begin
        if (exceed) begin
          m_we = 1'b1; m_wa = j_q[IdxBits-1:0]; m_wd = 1'b1;
        end
        j_d = j_q + 1'b1;
      end
      StDone: begin
        if (!kept_stall_i) begin
          cnt_d = '0;
          hold_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    box_stall_o  = (state_q != StLoad);
    kept_vld_o   = 1'b0;
    kept_index_o = hold_idx_q;
    kept_valid_o = 1'b1;
    run_end_o    = 1'b0;
    unique case (state_q)
      StEmit: kept_vld_o = hold_q;
      StDone: begin
        kept_vld_o   = 1'b1;
        run_end_o    = 1'b1;
        kept_valid_o = hold_q;
        if (!hold_q) kept_index_o = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      hold_q  <= 1'b0;
      sthr_q  <= ScoreThrRst;
      ithr_q  <= IouThrRst;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      hold_q  <= hold_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgScoreThr) sthr_q <= cfg_data_i;
        else ithr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    a_q        <= a_d;
    b_q        <= b_d;
    ga_q       <= ga_d;
    hold_idx_q <= hold_idx_d;
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> box_stall_o) else $error("input taken while busy");
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxBoxes)) else $error("box count overflow");
  a_set_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (n_q != '0 && n_q <= CntBits'(MaxBoxes)))
    else $error("bad set size");
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_vld_o && !kept_valid_o) |-> run_end_o) else $error("empty not last");
  a_kept_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_vld_o && kept_stall_i) |=> (kept_vld_o && $stable(kept_index_o) &&
    $stable(kept_valid_o) && $stable(run_end_o))) else $error("stalled result moved");
endmodule

[dv/gbn_checker.sv]
// ----------------------------------------------------------------------------
// gbn_checker
// Watches the box and kept channels, predicts the kept indices of each set
// with a greedy score-ordered IoU suppression model, and compares results.
// ----------------------------------------------------------------------------
module gbn_checker import gbn_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [CfgBits-1:0]          cfg_data_i,
  input  logic                        box_valid_i,
  input  logic                        box_stall_i,
  input  logic signed [CoordBits-1:0] box_left_i,
  input  logic signed [CoordBits-1:0] box_top_i,
  input  logic [SizeBits-1:0]         box_width_i,
  input  logic [SizeBits-1:0]         box_height_i,
  input  logic [ScoreBits-1:0]        box_score_i,
  input  logic                        final_box_i,
  input  logic                        kept_vld_i,
  input  logic                        kept_stall_i,
  input  logic [IdxBits-1:0]          kept_index_i,
  input  logic                        kept_valid_i,
  input  logic                        run_end_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          kept_seen_o
);
  typedef struct packed {
    logic [IdxBits-1:0] idx;
    logic               vld;
    logic               last;
  } kept_t;

  geom_t               geom_q [MaxBoxes];
  logic [ScoreBits-1:0] score_q [MaxBoxes];
  int                  box_cnt;
  logic [15:0]         score_thr;
  logic [15:0]         iou_thr;
  kept_t               kept_exp_q [$];

  assign pending_o = kept_exp_q.size();

  function automatic longint span_ov(longint a0, longint al, longint b0, longint bl);
    longint lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = (a0 + al - 1) < (b0 + bl - 1) ? (a0 + al - 1) : (b0 + bl - 1);
    return (hi - lo + 1) > 0 ? hi - lo + 1 : 0;
  endfunction

  function automatic bit overlaps_too_much(geom_t a, geom_t b);
    longint iw, ih, inter, uni;
    iw = span_ov(a.left, a.wid, b.left, b.wid);
    ih = span_ov(a.top, a.hgt, b.top, b.hgt);
    inter = iw * ih;
    uni = longint'(a.wid) * a.hgt + longint'(b.wid) * b.hgt - inter;
    return (inter * 65536) > (longint'(iou_thr) * uni);
  endfunction

  task automatic predict_kept_set();
    int    order [MaxBoxes];
    bit    supp [MaxBoxes];
    int    i, j, cur, nk;
    kept_t k;
    for (i = 0; i < box_cnt; i++) begin
      j = i;
      while (j > 0 && score_q[order[j-1]] < score_q[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      supp[i] = 0;
    end
    nk = 0;
    for (i = 0; i < box_cnt; i++) begin
      cur = order[i];
      if (score_q[cur] < score_thr || supp[i]) continue;
      k.idx = IdxBits'(cur); k.vld = 1; k.last = 0;
      kept_exp_q.insert(kept_exp_q.size(), k);
      nk++;
      for (j = i + 1; j < box_cnt; j++)
        if (!supp[j] && overlaps_too_much(geom_q[cur], geom_q[order[j]])) supp[j] = 1;
    end
    if (nk == 0) begin
      k.idx = '0; k.vld = 0; k.last = 1;
      kept_exp_q.insert(kept_exp_q.size(), k);
    end else begin
      kept_exp_q[kept_exp_q.size()-1].last = 1;
    end
    box_cnt = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t e;
    if (!rst_ni) begin
      box_cnt = 0;
      score_thr = 16'd16384;
      iou_thr = 16'd29491;
      fail_count_o = 0;
      kept_seen_o = 0;
      kept_exp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgScoreThr) score_thr = cfg_data_i;
        else iou_thr = cfg_data_i;
      end
      if (kept_vld_i && !kept_stall_i) begin
        kept_seen_o++;
        if (kept_exp_q.size() == 0) begin
          $error("unexpected kept transaction idx=%0d", kept_index_i);
          fail_count_o++;
        end else begin
          e = kept_exp_q.pop_front();
          if (kept_index_i !== e.idx) begin
            $error("kept_index exp=%0d act=%0d", e.idx, kept_index_i);
            fail_count_o++;
          end
          if (kept_valid_i !== e.vld) begin
            $error("kept_valid exp=%0d act=%0d", e.vld, kept_valid_i);
            fail_count_o++;
          end
          if (run_end_i !== e.last) begin
            $error("run_end exp=%0d act=%0d", e.last, run_end_i);
            fail_count_o++;
          end
        end
      end
      if (box_valid_i && !box_stall_i) begin
        if (box_cnt < MaxBoxes) begin
          geom_q[box_cnt] = '{box_left_i, box_top_i, box_width_i, box_height_i};
          score_q[box_cnt] = box_score_i;
          box_cnt++;
        end
        if (final_box_i) predict_kept_set();
      end
    end
  end
endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives box sets and threshold settings into the suppression unit with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import gbn_pkg::*;

  logic                        clk_i = 0;
  logic                        rst_ni = 0;
  logic                        cfg_we_i = 0;
  logic                        cfg_idx_i = 0;
  logic [CfgBits-1:0]          cfg_data_i = '0;
  logic                        box_valid_i = 0;
  logic                        box_stall_o;
  logic signed [CoordBits-1:0] box_left_i = '0;
  logic signed [CoordBits-1:0] box_top_i = '0;
  logic [SizeBits-1:0]         box_width_i = '0;
  logic [SizeBits-1:0]         box_height_i = '0;
  logic [ScoreBits-1:0]        box_score_i = '0;
  logic                        final_box_i = 0;
  logic                        kept_vld_o;
  logic                        kept_stall_i = 0;
  logic [IdxBits-1:0]          kept_index_o;
  logic                        kept_valid_o;
  logic                        run_end_o;
  int                          fail_count, pending, kept_seen;
  int                          send_idle_pct, recv_idle_pct;
  int                          boxes_sent, sets_sent;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  greedy_box_nms_unit dut (.*);

  gbn_checker u_checker (
    .box_stall_i(box_stall_o), .kept_vld_i(kept_vld_o), .kept_index_i(kept_index_o),
    .kept_valid_i(kept_valid_o), .run_end_i(run_end_o), .fail_count_o(fail_count),
    .pending_o(pending), .kept_seen_o(kept_seen), .*);

  always @(negedge clk_i)
    kept_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_box(int l, int t, int w, int h, int s, bit fin);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    box_valid_i  = 1'b1;
    box_left_i   = CoordBits'(l);
    box_top_i    = CoordBits'(t);
    box_width_i  = SizeBits'(w);
    box_height_i = SizeBits'(h);
    box_score_i  = ScoreBits'(s);
    final_box_i  = fin;
    while (box_stall_o) @(negedge clk_i);
    @(negedge clk_i);
    box_valid_i = 1'b0;
    boxes_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    wait_idle();
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // clustered boxes so that overlaps occur often
  task automatic random_set(int n);
    int cx, cy, i;
    cx = $urandom_range(8191) - 4096;
    cy = $urandom_range(8191) - 4096;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_box($urandom_range(8191) - 4096, $urandom_range(8191) - 4096,
                 $urandom_range(4095), $urandom_range(4095), $urandom, i == n - 1);
      else
        send_box(cx + $urandom_range(20) - 10, cy + $urandom_range(20) - 10,
                 $urandom_range(60), $urandom_range(60),
                 ($urandom_range(3) == 0) ? 16'h8000 : $urandom_range(65535), i == n - 1);
    end
  endtask

  initial begin
    #1000000;
    $display("[greedy_box_nms_unit] ERROR");
    $finish;
  end

  initial begin
    int ph, i;
    send_idle_pct = 0; recv_idle_pct = 0;
    boxes_sent = 0; sets_sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: extremes, ties, zero areas, nothing kept, overflow
    send_box(-4096, -4096, 4095, 4095, 65535, 0);
    send_box(4095, 4095, 4095, 4095, 65535, 0);
    send_box(-4096, -4096, 4095, 4095, 40000, 0);
    send_box(0, 0, 0, 0, 50000, 0);
    send_box(0, 0, 0, 0, 50000, 0);
    send_box(5, 5, 0, 7, 50000, 1);
    send_box(10, 10, 5, 5, 100, 1);
    write_reg(CfgScoreThr, 16'd0);
    write_reg(CfgIouThr, 16'd0);
    send_box(1, 1, 3, 3, 0, 0);
    send_box(3, 3, 3, 3, 0, 1);
    for (i = 0; i < MaxBoxes + 3; i++)
      send_box(i * 8, -i * 8, 4, 4, $urandom, i == MaxBoxes + 2);
    write_reg(CfgScoreThr, 16'hFFFF);
    write_reg(CfgIouThr, 16'hFFFF);
    send_box(0, 0, 10, 10, 16'hFFFF, 0);
    send_box(0, 0, 10, 10, 16'hFFFE, 1);

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 14 : 0;
      write_reg(CfgScoreThr, CfgBits'($urandom_range(40000)));
      write_reg(CfgIouThr, CfgBits'($urandom_range(65535)));
      for (i = 0; i < 4; i++) random_set($urandom_range(5, 1));
    end
    wait_idle();
    $display("sent %0d boxes in %0d sets, %0d kept transactions checked",
             boxes_sent, sets_sent, kept_seen);
    if (fail_count == 0)
      $display("[greedy_box_nms_unit] OK");
    else
      $display("[greedy_box_nms_unit] ERROR");
    $finish;
  end
endmodule
